// ----- sv/ccrc_pkg.sv -----
// Shared types and constants for the configurable CRC engine.
// No dependencies; imported by every module of the block.
package ccrc_pkg;

  localparam int unsigned CrcW   = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned IdxW   = 3;

  // register indexes (byte address / 4)
  localparam logic [IdxW-1:0] REG_CRC_WIDTH   = 3'd0;
  localparam logic [IdxW-1:0] REG_POLYNOMIAL  = 3'd1;
  localparam logic [IdxW-1:0] REG_INIT_VALUE  = 3'd2;
  localparam logic [IdxW-1:0] REG_REVERSE_IN  = 3'd3;
  localparam logic [IdxW-1:0] REG_REVERSE_OUT = 3'd4;
  localparam logic [IdxW-1:0] REG_INVERT_OUT  = 3'd5;

  // width codes; code 3 behaves as the 8-bit width
  localparam logic [1:0] WIDTH_32 = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_8  = 2'd2;
  localparam logic [1:0] WIDTH_8X = 2'd3;

  localparam logic [CrcW-1:0] POLY_RESET = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] INIT_RESET = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] MASK_16    = 32'h0000_FFFF;
  localparam logic [CrcW-1:0] MASK_8     = 32'h0000_00FF;
  localparam logic [CrcW-1:0] MASK_32    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]      crc_width;
    logic [CrcW-1:0] polynomial;
    logic [CrcW-1:0] init_value;
    logic            reverse_input;
    logic            reverse_output;
    logic            invert_output;
  } cfg_t;

endpackage

// ----- sv/ccrc_regs.sv -----
// APB-style configuration register file of the CRC engine.
// Depends on ccrc_pkg for the register map and the cfg_t bundle.
module ccrc_regs
  import ccrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t            cfg_r;
  logic            wr_en;
  logic [IdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_width      <= WIDTH_32;
      cfg_r.polynomial     <= POLY_RESET;
      cfg_r.init_value     <= INIT_RESET;
      cfg_r.reverse_input  <= 1'b0;
      cfg_r.reverse_output <= 1'b0;
      cfg_r.invert_output  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_CRC_WIDTH:   cfg_r.crc_width      <= pwdata[1:0];
        REG_POLYNOMIAL:  cfg_r.polynomial     <= pwdata;
        REG_INIT_VALUE:  cfg_r.init_value     <= pwdata;
        REG_REVERSE_IN:  cfg_r.reverse_input  <= pwdata[0];
        REG_REVERSE_OUT: cfg_r.reverse_output <= pwdata[0];
        REG_INVERT_OUT:  cfg_r.invert_output  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRC_WIDTH:   prdata = {30'd0, cfg_r.crc_width};
      REG_POLYNOMIAL:  prdata = cfg_r.polynomial;
      REG_INIT_VALUE:  prdata = cfg_r.init_value;
      REG_REVERSE_IN:  prdata = {31'd0, cfg_r.reverse_input};
      REG_REVERSE_OUT: prdata = {31'd0, cfg_r.reverse_output};
      REG_INVERT_OUT:  prdata = {31'd0, cfg_r.invert_output};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/ccrc_fold.sv -----
// Unrolled CRC fold network plus output post-processing.
// Depends on ccrc_pkg for cfg_t and the width masks.
module ccrc_fold
  import ccrc_pkg::*;
(
  input  cfg_t            cfg,
  input  logic [CrcW-1:0] crc_cur,
  input  logic            restart,
  input  logic [31:0]     data,
  input  logic            is_word,
  output logic [CrcW-1:0] crc_next,
  output logic [CrcW-1:0] crc_result
);

  logic            w8;
  logic            w16;
  logic [CrcW-1:0] mask;

  assign w8   = cfg.crc_width[1];
  assign w16  = !cfg.crc_width[1] && cfg.crc_width[0];
  assign mask = w8 ? MASK_8 : (w16 ? MASK_16 : MASK_32);

  // fold: one shift/xor step per data bit, MSB first
  always_comb begin
    logic [31:0]     din;
    logic [31:0]     aligned;
    logic [CrcW-1:0] c;
    logic [CrcW-1:0] poly;
    logic            topb;
    din = is_word ? data : {24'd0, data[7:0]};
    if (cfg.reverse_input) begin
      for (int b = 0; b < 4; b++) begin
        for (int k = 0; k < 8; k++) begin
          din[8*b+k] = (is_word ? data[8*b+7-k] : (b == 0 ? data[7-k] : 1'b0));
        end
      end
    end
    aligned = is_word ? din : {din[7:0], 24'd0};
    poly    = cfg.polynomial & mask;
    c       = (restart ? cfg.init_value : crc_cur) & mask;
    for (int i = 0; i < 32; i++) begin
      if (i < 8 || is_word) begin
        topb = w8 ? c[7] : (w16 ? c[15] : c[31]);
        c    = (c << 1) & mask;
        if (topb ^ aligned[31-i]) c = c ^ poly;
      end
    end
    crc_next = c;
  end

  // reverse over the active width, then complement (not at 8 bits)
  always_comb begin
    logic [CrcW-1:0] r;
    r = crc_next;
    if (cfg.reverse_output) begin
      r = '0;
      if (w8) begin
        for (int k = 0; k < 8; k++) r[k] = crc_next[7-k];
      end else if (w16) begin
        for (int k = 0; k < 16; k++) r[k] = crc_next[15-k];
      end else begin
        for (int k = 0; k < 32; k++) r[k] = crc_next[31-k];
      end
    end
    if (cfg.invert_output && !w8) r = r ^ mask;
    crc_result = r & mask;
  end

endmodule

// ----- sv/configurable_crc_engine.sv -----
// Top level of the configurable CRC engine: handshake, pipeline, CRC state.
// Depends on ccrc_pkg, ccrc_regs and ccrc_fold.
//
// Programmable CRC generator for 8-, 16- and 32-bit polynomials. Each request
// carries a byte or a 32-bit word that is folded MSB first into the running
// CRC; a restart request loads init_value before folding. Every request
// returns exactly one result: the CRC after that request, optionally
// bit-reversed over the active width and complemented (16/32-bit widths only),
// zero-extended to 32 bits, with last_out copied from last_in. The block
// sustains one request per clock while out_stall is low: a request is
// captured in an input register, folded by a fully unrolled 32-step XOR
// network in the next cycle, and written to the result register together
// with the new CRC state once the result register is free or drains, so
// out_valid rises as the request leaves the input register. The result
// register decouples the two channels; while a result is stalled, one
// further request is still held in the input register. Configuration is
// written through the APB port (register i at byte address 4*i) and must
// only change while the block is idle. No clearing pass is needed after reset.
module configurable_crc_engine
  import ccrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [31:0]      in_data_in,
  input  logic             in_data_is_word,
  input  logic             in_last_in,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_crc_value,
  output logic             out_last_out,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t            cfg;

  // input register stage
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_req_r;
  logic [31:0]     s1_data_r;
  logic            s1_word_r;
  logic            s1_last_r;

  // result register stage and running CRC
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_crc_r;
  logic            out_last_r;
  logic [CrcW-1:0] crc_r;

  logic            in_take;
  logic            s1_adv;
  logic [CrcW-1:0] crc_next;
  logic [CrcW-1:0] crc_result;

  ccrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccrc_fold u_fold (
    .cfg        (cfg),
    .crc_cur    (crc_r),
    .restart    (s1_req_r),
    .data       (s1_data_r),
    .is_word    (s1_word_r),
    .crc_next   (crc_next),
    .crc_result (crc_result)
  );

  // Advance the held request whenever the result register is free or drains
  // this cycle; stall the request side only when the held request cannot move.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= INIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // commit the new CRC state as the request leaves the input stage
      if (s1_adv) crc_r <= crc_next;
    end
  end

  // payload registers: input stage captures on accept, result stage on advance; hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r  <= in_req_type;
      s1_data_r <= in_data_in;
      s1_word_r <= in_data_is_word;
      s1_last_r <= in_last_in;
    end
    if (s1_adv) begin
      out_crc_r  <= crc_result;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;
  assign out_last_out  = out_last_r;

`ifndef SYNTHESIS
  a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("request stalled without a blocked held request");

  a_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_adv && $past(rst_n)) |=> $stable(crc_r))
    else $error("CRC state changed without a request advancing");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after being taken");

  a_narrow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cfg.crc_width == WIDTH_8 || cfg.crc_width == WIDTH_8X))
      |-> (out_crc_r[31:8] == 24'd0))
    else $error("8-bit result not zero-extended");
`endif

endmodule
